FILE: rtl/core/dqpb_pkg.sv
// ----------------------------------------------------------------------------
// dqpb_pkg
// Shared constants and byte tables for the DNS query packet builder.
// ----------------------------------------------------------------------------
package dqpb_pkg;

   // default longest label kept in the label buffer
   localparam int MAX_LABEL_DEF = 63;

   // name characters with a meaning of their own
   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] END_CHAR = 8'h00;

   // fixed header and question fields
   localparam logic [15:0] HDR_FLAGS   = 16'h0100;
   localparam logic [15:0] HDR_QDCOUNT = 16'h0001;
   localparam logic [15:0] Q_TYPE      = 16'h0001;
   localparam logic [15:0] Q_CLASS     = 16'h0001;

   localparam int HDR_BYTES = 12;
   localparam int TRL_BYTES = 5;

   // header byte at a position, id high byte first
   function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [15:0] qid);
      logic [7:0] b;
      case (pos)
         4'd0:    b = qid[15:8];
         4'd1:    b = qid[7:0];
         4'd2:    b = HDR_FLAGS[15:8];
         4'd3:    b = HDR_FLAGS[7:0];
         4'd4:    b = HDR_QDCOUNT[15:8];
         4'd5:    b = HDR_QDCOUNT[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // trailer byte: root label, then type and class
   function automatic logic [7:0] trl_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd1:    b = Q_TYPE[15:8];
         3'd2:    b = Q_TYPE[7:0];
         3'd3:    b = Q_CLASS[15:8];
         3'd4:    b = Q_CLASS[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/core/dqpb_ram.sv
// ----------------------------------------------------------------------------
// dqpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqpb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 63,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dns_query_packet_builder.sv
// ----------------------------------------------------------------------------
// dns_query_packet_builder
// Encodes a dotted domain name, one character a beat, into a DNS query
// packet delivered as byte pairs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_name_char
//  rsp     | out       | rsp_valid/rsp_stall | byte pair, flags
//  csr     | in        | csr_valid/csr_ready | csr_query_id
//
//  A plain character with no header pending is buffered and the builder
//  stays idle. Every other item emits its packet bytes one at a time
//  (12 header, 1 + label length, 5 trailer) through the single byte
//  path and the one read port of the label RAM.
//  Reset is synchronous; the label RAM is not cleared, since only entries
//  of the current label are read.
//  rsp_stall on a waiting pair lets at most one more byte into the half
//  pair, then holds the byte sequencer until the pair is taken.
// ----------------------------------------------------------------------------
module dns_query_packet_builder
   import dqpb_pkg::*;
#(
   parameter int MAX_LABEL = MAX_LABEL_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_name_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_first_byte,
   output logic [7:0]  rsp_second_byte,
   output logic        rsp_second_valid,
   output logic        rsp_run_last,
   output logic        rsp_packet_end,
   output logic        rsp_label_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_query_id
);

   localparam int LEN_W  = $clog2(MAX_LABEL + 1);
   localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam int IDX_W  = (LEN_W > 4) ? LEN_W : 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_LEN,
      ST_LBL,
      ST_TRL
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] label_len_ff, label_len_in;
   logic [LEN_W-1:0] flush_len_ff, flush_len_in;
   logic             packet_start_ff, packet_start_in;
   logic             ovf_seen_ff, ovf_seen_in;
   logic             flush_ff, flush_in;
   logic             end_ff, end_in;
   logic             ovf_ff, ovf_in;
   logic [15:0]      qid_ff, qid_in;
   logic             have_half_ff, have_half_in;
   logic [7:0]       half_ff, half_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       second_ff, second_in;
   logic             second_valid_ff, second_valid_in;
   logic             run_last_ff, run_last_in;
   logic             packet_end_ff, packet_end_in;
   logic             label_ovf_ff, label_ovf_in;

   logic             req_take;
   logic             is_flush;
   logic             is_end;
   logic             wr_en;
   logic [7:0]       rd_data;
   logic [7:0]       byte_val;
   logic             byte_last;
   logic             byte_take;
   logic             out_free;
   logic             lbl_done;

   // label buffer
   dqpb_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LABEL)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (label_len_ff[ADDR_W-1:0]),
      .wr_data (req_name_char),
      .rd_addr (idx_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign is_end    = (req_name_char == END_CHAR);
   assign is_flush  = is_end || (req_name_char == DOT_CHAR);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign lbl_done  = (IDX_W'(idx_ff + 1'b1) == IDX_W'(flush_len_ff));

   // select the current packet byte
   always_comb begin
      byte_val  = 8'h00;
      byte_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            byte_val  = 8'h00;
            byte_last = 1'b0;
         end
         ST_HDR: begin
            byte_val  = hdr_byte(idx_ff[3:0], qid_ff);
            byte_last = (idx_ff == IDX_W'(HDR_BYTES - 1)) && !flush_ff;
         end
         ST_LEN: begin
            byte_val  = 8'(flush_len_ff);
            byte_last = (flush_len_ff == '0) && !end_ff;
         end
         ST_LBL: begin
            byte_val  = rd_data;
            byte_last = lbl_done && !end_ff;
         end
         ST_TRL: begin
            byte_val  = trl_byte(idx_ff[2:0]);
            byte_last = (idx_ff == IDX_W'(TRL_BYTES - 1));
         end
         default: begin
            byte_val  = 8'h00;
            byte_last = 1'b0;
         end
      endcase
   end

   // a byte advances unless it must close a pair while the output is held
   assign byte_take = (state_ff != ST_IDLE) &&
                      (out_free || (!have_half_ff && !byte_last));

   // sequencer, label bookkeeping and pair assembly
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      label_len_in    = label_len_ff;
      flush_len_in    = flush_len_ff;
      packet_start_in = packet_start_ff;
      ovf_seen_in     = ovf_seen_ff;
      flush_in        = flush_ff;
      end_in          = end_ff;
      ovf_in          = ovf_ff;
      qid_in          = qid_ff;
      have_half_in    = have_half_ff;
      half_in         = half_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      second_valid_in = second_valid_ff;
      run_last_in     = run_last_ff;
      packet_end_in   = packet_end_ff;
      label_ovf_in    = label_ovf_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      wr_en           = 1'b0;

      if (csr_valid) begin
         qid_in = csr_query_id;
      end

      // accept a character
      if (req_take) begin
         if (packet_start_ff) begin
            state_in        = ST_HDR;
            packet_start_in = 1'b0;
         end else if (is_flush) begin
            state_in = ST_LEN;
         end
         if (is_flush) begin
            flush_in     = 1'b1;
            end_in       = is_end;
            ovf_in       = ovf_seen_ff;
            flush_len_in = label_len_ff;
            label_len_in = '0;
            ovf_seen_in  = 1'b0;
            if (is_end) begin
               packet_start_in = 1'b1;
            end
         end else begin
            flush_in = 1'b0;
            end_in   = 1'b0;
            ovf_in   = 1'b0;
            if (label_len_ff < LEN_W'(MAX_LABEL)) begin
               wr_en        = 1'b1;
               label_len_in = label_len_ff + 1'b1;
            end else begin
               ovf_seen_in = 1'b1;
            end
         end
      end

      // advance through header, length, label and trailer
      if (byte_take) begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_in = '0;
            end
            ST_HDR: begin
               if (idx_ff == IDX_W'(HDR_BYTES - 1)) begin
                  state_in = flush_ff ? ST_LEN : ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            ST_LEN: begin
               idx_in = '0;
               if (flush_len_ff != '0) begin
                  state_in = ST_LBL;
               end else begin
                  state_in = end_ff ? ST_TRL : ST_IDLE;
               end
            end
            ST_LBL: begin
               if (lbl_done) begin
                  state_in = end_ff ? ST_TRL : ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            ST_TRL: begin
               if (idx_ff == IDX_W'(TRL_BYTES - 1)) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end
         endcase

         // pair bytes; close a half pair at the item's last byte
         if (have_half_ff || byte_last) begin
            rsp_valid_in    = 1'b1;
            have_half_in    = 1'b0;
            first_in        = have_half_ff ? half_ff : byte_val;
            second_in       = have_half_ff ? byte_val : 8'h00;
            second_valid_in = have_half_ff;
            run_last_in     = byte_last;
            packet_end_in   = byte_last && end_ff;
            label_ovf_in    = ovf_ff;
         end else begin
            have_half_in = 1'b1;
            half_in      = byte_val;
         end
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         label_len_ff    <= '0;
         packet_start_ff <= 1'b1;
         ovf_seen_ff     <= 1'b0;
         flush_ff        <= 1'b0;
         end_ff          <= 1'b0;
         ovf_ff          <= 1'b0;
         qid_ff          <= '0;
         have_half_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         label_len_ff    <= label_len_in;
         packet_start_ff <= packet_start_in;
         ovf_seen_ff     <= ovf_seen_in;
         flush_ff        <= flush_in;
         end_ff          <= end_in;
         ovf_ff          <= ovf_in;
         qid_ff          <= qid_in;
         have_half_ff    <= have_half_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      flush_len_ff    <= flush_len_in;
      half_ff         <= half_in;
      first_ff        <= first_in;
      second_ff       <= second_in;
      second_valid_ff <= second_valid_in;
      run_last_ff     <= run_last_in;
      packet_end_ff   <= packet_end_in;
      label_ovf_ff    <= label_ovf_in;
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_byte     = first_ff;
   assign rsp_second_byte    = second_ff;
   assign rsp_second_valid   = second_valid_ff;
   assign rsp_run_last       = run_last_ff;
   assign rsp_packet_end     = packet_end_ff;
   assign rsp_label_overflow = label_ovf_ff;

endmodule

FILE: rtl/core/dqpb_checker.sv
// ----------------------------------------------------------------------------
// dqpb_checker
// Port-level checks on the result stream of the DNS query packet builder.
// ----------------------------------------------------------------------------
module dqpb_checker
   import dqpb_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_first_byte,
   input logic [7:0] rsp_second_byte,
   input logic       rsp_second_valid,
   input logic       rsp_run_last,
   input logic       rsp_packet_end
);

   // a stalled beat holds its pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_first_byte) &&
      $stable(rsp_second_byte) && $stable(rsp_second_valid))
      else $error("stalled result beat changed");

   // a half-filled pair only closes an item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_second_valid |-> rsp_run_last &&
      (rsp_second_byte == 8'h00))
      else $error("half pair not at item end");

   // packet end is the item's last beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_run_last)
      else $error("packet end without run last");

   // packet ends on the class low byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |->
      ((rsp_second_valid && (rsp_second_byte == Q_CLASS[7:0])) ||
       (!rsp_second_valid && (rsp_first_byte == Q_CLASS[7:0]))))
      else $error("packet does not end with query class");

endmodule

bind dns_query_packet_builder dqpb_checker u_dqpb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_first_byte   (rsp_first_byte),
   .rsp_second_byte  (rsp_second_byte),
   .rsp_second_valid (rsp_second_valid),
   .rsp_run_last     (rsp_run_last),
   .rsp_packet_end   (rsp_packet_end)
);
